[sv/bbp_pkg.sv]
// bbp_pkg: shared constants, command codes and the queue head control struct
// for the bicubic bezier patch evaluator; no dependencies
`default_nettype none
package bbp_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // command codes carried in the cmd field
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam int GRID_DIM    = 4;
  localparam int GRID_POINTS = GRID_DIM * GRID_DIM;
  localparam int GRID_IDX_W  = 4;
  localparam int NUM_AXES    = 3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one interpolation step: difference, partial products, sum
  localparam int LERP_LAT    = 3;
  // three steps along u, three along v
  localparam int NUM_LEVELS  = 6;

  typedef struct packed {
    logic                  valid;
    logic                  eval;
    logic [GRID_IDX_W-1:0] idx;
  } head_ctl_t;

endpackage
`default_nettype wire

[sv/bbp_if.sv]
// bbp_in_if and bbp_out_if: valid/ready channels of the patch evaluator
// depends on bbp_pkg for the default widths
`default_nettype none
interface bbp_in_if import bbp_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [1:0]                    grid_row;
  logic [1:0]                    grid_col;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic [PARAM_FRAC_BITS:0]      param_u;
  logic [PARAM_FRAC_BITS:0]      param_v;

  modport source (output valid, cmd, grid_row, grid_col, point_x, point_y, point_z,
                  param_u, param_v, input ready);
  modport sink   (input valid, cmd, grid_row, grid_col, point_x, point_y, point_z,
                  param_u, param_v, output ready);
endinterface

interface bbp_out_if import bbp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] surf_x;
  logic signed [COORD_WIDTH-1:0] surf_y;
  logic signed [COORD_WIDTH-1:0] surf_z;

  modport source (output valid, surf_x, surf_y, surf_z, input ready);
  modport sink   (input valid, surf_x, surf_y, surf_z, output ready);
endinterface
`default_nettype wire

[sv/bbp_front.sv]
// bbp_front: accepts transactions, saturates u and v, decodes the grid index
// and queues the commands; depends on bbp_pkg and bbp_in_if
`default_nettype none
module bbp_front import bbp_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bbp_in_if.sink                             in_ch,
  input  wire logic                          hd_pop,
  output head_ctl_t                          hd_ctl,
  output logic signed [COORD_WIDTH-1:0]      hd_x,
  output logic signed [COORD_WIDTH-1:0]      hd_y,
  output logic signed [COORD_WIDTH-1:0]      hd_z,
  output logic [PARAM_FRAC_BITS:0]           hd_u,
  output logic [PARAM_FRAC_BITS:0]           hd_v
);

  localparam logic [PARAM_FRAC_BITS:0] T_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  logic                          q_eval_r [QUEUE_DEPTH];
  logic [GRID_IDX_W-1:0]         q_idx_r  [QUEUE_DEPTH];
  logic signed [COORD_WIDTH-1:0] q_x_r    [QUEUE_DEPTH];
  logic signed [COORD_WIDTH-1:0] q_y_r    [QUEUE_DEPTH];
  logic signed [COORD_WIDTH-1:0] q_z_r    [QUEUE_DEPTH];
  logic [PARAM_FRAC_BITS:0]      q_u_r    [QUEUE_DEPTH];
  logic [PARAM_FRAC_BITS:0]      q_v_r    [QUEUE_DEPTH];
  logic [QPTR_W-1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]             cnt_r, cnt_nxt;
  logic                          push;
  logic [PARAM_FRAC_BITS:0]      u_sat, v_sat;

  assign in_ch.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  // anything above 1.0 clamps to exactly 1.0
  assign u_sat = in_ch.param_u[PARAM_FRAC_BITS] ? T_ONE : in_ch.param_u;
  assign v_sat = in_ch.param_v[PARAM_FRAC_BITS] ? T_ONE : in_ch.param_v;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = hd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(hd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_eval_r[wr_ptr_r] <= (in_ch.cmd == CMD_EVAL);
      q_idx_r[wr_ptr_r]  <= {in_ch.grid_row, in_ch.grid_col};
      q_x_r[wr_ptr_r]    <= in_ch.point_x;
      q_y_r[wr_ptr_r]    <= in_ch.point_y;
      q_z_r[wr_ptr_r]    <= in_ch.point_z;
      q_u_r[wr_ptr_r]    <= u_sat;
      q_v_r[wr_ptr_r]    <= v_sat;
    end
  end

  always_comb begin
    hd_ctl.valid = (cnt_r != '0);
    hd_ctl.eval  = q_eval_r[rd_ptr_r];
    hd_ctl.idx   = q_idx_r[rd_ptr_r];
    hd_x         = q_x_r[rd_ptr_r];
    hd_y         = q_y_r[rd_ptr_r];
    hd_z         = q_z_r[rd_ptr_r];
    hd_u         = q_u_r[rd_ptr_r];
    hd_v         = q_v_r[rd_ptr_r];
  end

endmodule
`default_nettype wire

[sv/bbp_lerp.sv]
// bbp_lerp: exact three-stage interpolation y = a*2^F + (b - a)*t
// no package dependency; used by bbp_eval
`default_nettype none
module bbp_lerp #(
  parameter int IN_W = 32,
  parameter int TW   = 17,
  parameter int MW   = 128
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [TW-1:0]        t,
  input  wire logic signed [MW-1:0] a,
  input  wire logic signed [MW-1:0] b,
  output logic signed [MW-1:0]      y
);

  localparam int F  = TW - 1;
  localparam int DW = IN_W + 1;
  localparam int NC = (DW + 31) / 32;
  localparam int PW = TW + 34;
  localparam int SW = NC * 32 + TW + 2;
  localparam int OW = IN_W + F;

  logic signed [DW-1:0]      diff_r;
  logic signed [IN_W-1:0]    a1_r, a2_r;
  logic [TW-1:0]             t_r;
  logic signed [TW:0]        t_s;
  logic signed [PW-1:0]      prod_r [NC];
  logic signed [NC*32-1:0]   dx;
  logic signed [SW-1:0]      acc;
  logic signed [OW-1:0]      y_r;

  assign dx  = (NC*32)'(diff_r);
  assign t_s = {1'b0, t_r};

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= $signed({b[IN_W-1], b[IN_W-1:0]}) - $signed({a[IN_W-1], a[IN_W-1:0]});
      a1_r   <= a[IN_W-1:0];
      t_r    <= t;
      a2_r   <= a1_r;
      y_r    <= acc[OW-1:0];
    end
  end

  // 32-bit slices of the difference, only the top slice is signed
  for (genvar k = 0; k < NC; k++) begin : gen_chunk
    logic signed [32:0] op;
    if (k == NC - 1) begin : gen_top
      assign op = {dx[32*k+31], dx[32*k +: 32]};
    end else begin : gen_low
      assign op = {1'b0, dx[32*k +: 32]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[k] <= op * t_s;
      end
    end
  end

  always_comb begin
    acc = SW'(a2_r) <<< F;
    for (int k = 0; k < NC; k++) begin
      acc = acc + (SW'(prod_r[k]) <<< (32 * k));
    end
  end

  assign y = MW'(y_r);

endmodule
`default_nettype wire

[sv/bbp_eval.sv]
// bbp_eval: control point store and the de casteljau pipeline that turns
// queued commands into surface points; depends on bbp_pkg and bbp_lerp
`default_nettype none
module bbp_eval import bbp_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire head_ctl_t                     hd_ctl,
  input  wire logic signed [COORD_WIDTH-1:0] hd_x,
  input  wire logic signed [COORD_WIDTH-1:0] hd_y,
  input  wire logic signed [COORD_WIDTH-1:0] hd_z,
  input  wire logic [PARAM_FRAC_BITS:0]      hd_u,
  input  wire logic [PARAM_FRAC_BITS:0]      hd_v,
  output logic                               hd_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z
);

  localparam int W      = COORD_WIDTH;
  localparam int F      = PARAM_FRAC_BITS;
  localparam int TW     = F + 1;
  localparam int SH     = NUM_LEVELS * F;
  localparam int MW     = W + SH;
  localparam int LAT    = NUM_LEVELS * LERP_LAT;
  localparam int U_TAPS = (GRID_DIM - 2) * LERP_LAT + 1;
  localparam int V_TAPS = (NUM_LEVELS - 1) * LERP_LAT + 1;
  localparam logic [MW:0] HALF = (MW+1)'(1) << (SH - 1);

  logic signed [W-1:0]  st_r  [NUM_AXES][GRID_POINTS];
  logic signed [W-1:0]  pt0_r [NUM_AXES][GRID_POINTS];
  logic [TW-1:0]        t_u_r [U_TAPS];
  logic [TW-1:0]        t_v_r [V_TAPS];
  logic                 vld_r [LAT+1];
  logic                 out_valid_r;
  logic signed [W-1:0]  res_r [NUM_AXES];
  logic signed [MW-1:0] un [NUM_AXES][GRID_DIM][GRID_DIM][GRID_DIM];
  logic signed [MW-1:0] vn [NUM_AXES][GRID_DIM][GRID_DIM];
  logic signed [MW:0]   rsum [NUM_AXES];
  logic                 en;

  // whole pipeline advances together, stalls only on a held result
  assign en     = !out_valid_r || out_ready;
  assign hd_pop = hd_ctl.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int n = 0; n < GRID_POINTS; n++) begin
          st_r[a][n] <= '0;
        end
      end
    end else if (hd_pop && !hd_ctl.eval) begin
      st_r[0][hd_ctl.idx] <= hd_x;
      st_r[1][hd_ctl.idx] <= hd_y;
      st_r[2][hd_ctl.idx] <= hd_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= hd_ctl.valid && hd_ctl.eval;
      for (int k = 1; k <= LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt0_r    <= st_r;
      t_u_r[0] <= hd_u;
      t_v_r[0] <= hd_v;
      for (int k = 1; k < U_TAPS; k++) begin
        t_u_r[k] <= t_u_r[k-1];
      end
      for (int k = 1; k < V_TAPS; k++) begin
        t_v_r[k] <= t_v_r[k-1];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        res_r[a] <= rsum[a][SH +: W];
      end
    end
  end

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : gen_axis
    // reduce each column along u
    for (genvar j = 0; j < GRID_DIM; j++) begin : gen_col
      for (genvar i = 0; i < GRID_DIM; i++) begin : gen_pt0
        assign un[ax][0][j][i] = MW'(pt0_r[ax][i*GRID_DIM+j]);
      end
      for (genvar l = 1; l < GRID_DIM; l++) begin : gen_ulvl
        for (genvar i = 0; i < GRID_DIM; i++) begin : gen_un
          if (i < GRID_DIM - l) begin : gen_lerp
            bbp_lerp #(.IN_W(W + (l-1)*F), .TW(TW), .MW(MW)) u_lerp (
              .clk (clk),
              .en  (en),
              .t   (t_u_r[(l-1)*LERP_LAT]),
              .a   (un[ax][l-1][j][i]),
              .b   (un[ax][l-1][j][i+1]),
              .y   (un[ax][l][j][i])
            );
          end else begin : gen_idle
            assign un[ax][l][j][i] = '0;
          end
        end
      end
      assign vn[ax][0][j] = un[ax][GRID_DIM-1][j][0];
    end
    // then the column results along v
    for (genvar l = 1; l < GRID_DIM; l++) begin : gen_vlvl
      for (genvar j = 0; j < GRID_DIM; j++) begin : gen_vn
        if (j < GRID_DIM - l) begin : gen_lerp
          bbp_lerp #(.IN_W(W + (l+2)*F), .TW(TW), .MW(MW)) u_lerp (
            .clk (clk),
            .en  (en),
            .t   (t_v_r[(l+2)*LERP_LAT]),
            .a   (vn[ax][l-1][j]),
            .b   (vn[ax][l-1][j+1]),
            .y   (vn[ax][l][j])
          );
        end else begin : gen_idle
          assign vn[ax][l][j] = '0;
        end
      end
    end
    // round half up, then drop the extra fraction
    assign rsum[ax] = $signed({vn[ax][GRID_DIM-1][0][MW-1], vn[ax][GRID_DIM-1][0]})
                      + $signed(HALF);
  end

  assign out_valid = out_valid_r;
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];

endmodule
`default_nettype wire

[sv/bicubic_bezier_patch_eval_unit.sv]
// bicubic_bezier_patch_eval_unit: top level of the bicubic bezier patch evaluator
// depends on bbp_pkg, bbp_if, bbp_front, bbp_eval and bbp_lerp
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+---------------------------------------------
//   in_ch    | in  | valid / ready   | cmd, grid_row, grid_col, point_x/y/z, param_u/v
//   out_ch   | out | valid / ready   | surf_x, surf_y, surf_z
//
// one transaction per cycle sustained while out_ch does not stall; an evaluate reaches out_ch
// after acceptance through the queue with a snapshot of the store as it leaves the queue,
// six interpolation levels of three stages each and rounding into the output register
// loads give no result and are applied to the point store as they leave the queue
// rst_n is synchronous: clears the point store to zero, the queue and all valids
// a stall on out_ch holds the whole evaluation pipeline; in_ch keeps
// accepting until the two-entry command queue is full
`default_nettype none
module bicubic_bezier_patch_eval_unit import bbp_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bbp_in_if.sink    in_ch,
  bbp_out_if.source out_ch
);

  // queue head between the front and the evaluation back end
  head_ctl_t                     hd_ctl;
  logic signed [COORD_WIDTH-1:0] hd_x, hd_y, hd_z;
  logic [PARAM_FRAC_BITS:0]      hd_u, hd_v;
  logic                          hd_pop;

  // front: accept, clamp u/v, queue the command
  bbp_front #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .hd_pop (hd_pop),
    .hd_ctl (hd_ctl),
    .hd_x   (hd_x),
    .hd_y   (hd_y),
    .hd_z   (hd_z),
    .hd_u   (hd_u),
    .hd_v   (hd_v)
  );

  // back: point store plus exact de casteljau pipeline
  bbp_eval #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .hd_ctl    (hd_ctl),
    .hd_x      (hd_x),
    .hd_y      (hd_y),
    .hd_z      (hd_z),
    .hd_u      (hd_u),
    .hd_v      (hd_v),
    .hd_pop    (hd_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.surf_x),
    .out_y     (out_ch.surf_y),
    .out_z     (out_ch.surf_z)
  );

endmodule
`default_nettype wire

[sv/bbp_checker.sv]
// bbp_checker: port-level assertions for the patch evaluator and its bind
// depends on bbp_pkg and bicubic_bezier_patch_eval_unit
`default_nettype none
module bbp_checker import bbp_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [W-1:0] surf_x,
  input wire logic [W-1:0] surf_y,
  input wire logic [W-1:0] surf_z
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(surf_x) && $stable(surf_y) && $stable(surf_z))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // with the output free the queue pops its head, so in_ready is high next cycle
  a_ready_after_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> in_ready)
    else $error("input blocked although output was free");

endmodule

bind bicubic_bezier_patch_eval_unit bbp_checker #(.W(COORD_WIDTH)) u_bbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .surf_x    (out_ch.surf_x),
  .surf_y    (out_ch.surf_y),
  .surf_z    (out_ch.surf_z)
);
`default_nettype wire

[test/bbp_test_if.sv]
// bbp_test_if: package bbp_test_pkg with the testbench item types for the evaluator channels
// the channel interfaces themselves come from the rtl file bbp_if.sv and bbp_pkg
`default_nettype none
package bbp_test_pkg;
  import bbp_pkg::*;

  // one input transaction as the driver holds it
  typedef struct {
    logic               cmd;
    logic [1:0]         grid_row;
    logic [1:0]         grid_col;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [16:0]        param_u;
    logic [16:0]        param_v;
  } patch_item_t;

  // one expected surface point
  typedef struct {
    logic signed [31:0] surf_x;
    logic signed [31:0] surf_y;
    logic signed [31:0] surf_z;
  } surf_point_t;
endpackage
`default_nettype wire

[test/bicubic_bezier_patch_eval_unit_test.sv]
// bicubic_bezier_patch_eval_unit_test: self-checking bench for the patch evaluator
// depends on bbp_pkg, bbp_if, bbp_test_pkg and the rtl of the block
`default_nettype none
module bicubic_bezier_patch_eval_unit_test;
  import bbp_pkg::*;
  import bbp_test_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = 16;
  localparam int ONE        = 1 << FRAC;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  bbp_in_if  in_ch ();
  bbp_out_if out_ch ();

  bicubic_bezier_patch_eval_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the control point grid, index row*4+col
  logic signed [31:0] grid_x [GRID_POINTS];
  logic signed [31:0] grid_y [GRID_POINTS];
  logic signed [31:0] grid_z [GRID_POINTS];

  patch_item_t pending_items[$];
  surf_point_t expected_points[$];

  int  send_idle_pct = 0;  // percent of cycles the sender holds off
  int  recv_stall_pct = 0; // percent of cycles the sink stalls
  int  mismatch_count = 0;
  int  idle_cycles = 0;

  // cubic bernstein weights scaled by 2^48, computed from the power basis matrix
  function automatic void bernstein_weights(input logic [16:0] raw,
                                            output logic signed [127:0] wt [4]);
    logic signed [127:0] t;
    logic signed [127:0] s;
    logic signed [127:0] pw [4];
    int basis [4][4];
    basis = '{'{-1, 3, -3, 1}, '{3, -6, 3, 0}, '{-3, 3, 0, 0}, '{1, 0, 0, 0}};
    t = (raw > 17'(ONE)) ? 128'(ONE) : 128'(raw);
    s = 128'(ONE);
    pw[0] = t * t * t;
    pw[1] = t * t * s;
    pw[2] = t * s * s;
    pw[3] = s * s * s;
    for (int i = 0; i < 4; i++) begin
      wt[i] = '0;
      for (int k = 0; k < 4; k++) begin
        wt[i] += 128'(signed'(basis[i][k])) * pw[k];
      end
    end
  endfunction

  // exact weighted sum then round half up at the output lsb
  function automatic logic signed [31:0] blend_axis(
      input logic signed [31:0] pts [GRID_POINTS],
      input logic signed [127:0] wu [4], input logic signed [127:0] wv [4]);
    logic signed [255:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc += 256'(wu[i]) * 256'(wv[j]) * 256'(pts[i*4+j]);
      end
    end
    acc += 256'(1) << (6*FRAC - 1);
    acc = acc >>> (6*FRAC);
    return acc[31:0];
  endfunction

  // apply one accepted transaction to the shadow grid or predict a point
  function automatic void predict_patch(input patch_item_t it);
    logic signed [127:0] wu [4];
    logic signed [127:0] wv [4];
    surf_point_t p;
    if (it.cmd == CMD_LOAD) begin
      grid_x[{it.grid_row, it.grid_col}] = it.point_x;
      grid_y[{it.grid_row, it.grid_col}] = it.point_y;
      grid_z[{it.grid_row, it.grid_col}] = it.point_z;
    end else begin
      bernstein_weights(it.param_u, wu);
      bernstein_weights(it.param_v, wv);
      p.surf_x = blend_axis(grid_x, wu, wv);
      p.surf_y = blend_axis(grid_y, wu, wv);
      p.surf_z = blend_axis(grid_z, wu, wv);
      expected_points.push_back(p);
    end
  endfunction

  // driver: presents the head of the queue, changes at the falling edge
  bit in_fire;
  bit in_wait = 1'b0;  // offered transaction not yet taken
  assign in_fire = in_ch.valid && in_ch.ready;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD;
    in_ch.grid_row = '0;
    in_ch.grid_col = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.param_u = '0;
    in_ch.param_v = '0;
    out_ch.ready = 1'b0;
  end

  // accepted transactions are recorded at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_fire) begin
      predict_patch(pending_items.pop_front());
    end
    in_wait <= rst_n && in_ch.valid && !in_ch.ready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (pending_items.size() > 0 &&
                 (in_wait || $urandom_range(99) >= send_idle_pct)) begin
      in_ch.valid    <= 1'b1;
      in_ch.cmd      <= pending_items[0].cmd;
      in_ch.grid_row <= pending_items[0].grid_row;
      in_ch.grid_col <= pending_items[0].grid_col;
      in_ch.point_x  <= pending_items[0].point_x;
      in_ch.point_y  <= pending_items[0].point_y;
      in_ch.point_z  <= pending_items[0].point_z;
      in_ch.param_u  <= pending_items[0].param_u;
      in_ch.param_v  <= pending_items[0].param_v;
    end else begin
      in_ch.valid <= 1'b0;
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: compares each accepted surface point with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected point x=%h y=%h z=%h",
                   out_ch.surf_x, out_ch.surf_y, out_ch.surf_z);
        end
      end else begin
        surf_point_t e;
        e = expected_points.pop_front();
        if (e.surf_x !== out_ch.surf_x || e.surf_y !== out_ch.surf_y ||
            e.surf_z !== out_ch.surf_z) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("point mismatch: expected %h %h %h got %h %h %h",
                     e.surf_x, e.surf_y, e.surf_z,
                     out_ch.surf_x, out_ch.surf_y, out_ch.surf_z);
          end
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (in_fire || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(signed'($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'(ONE);
      2: return 17'($urandom_range(131071, ONE + 1));  // saturates to one
      3: return 17'(ONE / 2);
      default: return 17'($urandom_range(ONE));
    endcase
  endfunction

  function automatic patch_item_t make_load(input int r, input int c,
      input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z);
    patch_item_t it;
    it.cmd = CMD_LOAD;
    it.grid_row = r[1:0];
    it.grid_col = c[1:0];
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.param_u = 17'($urandom);  // ignored on a load
    it.param_v = 17'($urandom);
    return it;
  endfunction

  function automatic patch_item_t make_eval(input logic [16:0] u, input logic [16:0] v);
    patch_item_t it;
    it.cmd = CMD_EVAL;
    it.grid_row = 2'($urandom);  // ignored on an evaluate
    it.grid_col = 2'($urandom);
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_z = $urandom;
    it.param_u = u;
    it.param_v = v;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_points.size() > 0 || in_ch.valid) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < GRID_POINTS; k++) begin
      grid_x[k] = '0;
      grid_y[k] = '0;
      grid_z[k] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: evaluate the cleared grid, corners, saturated and extreme grids
    pending_items.push_back(make_eval(17'd0, 17'(ONE)));
    pending_items.push_back(make_load(0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000));
    pending_items.push_back(make_load(3, 3, 32'sh80000000, 32'sh7fffffff, -32'sh00008000));
    pending_items.push_back(make_load(0, 3, 32'shffffffff, 32'sh00000001, 32'sh55555555));
    pending_items.push_back(make_load(3, 0, 32'sh00000001, 32'shffffffff, 32'shaaaaaaaa));
    pending_items.push_back(make_eval(17'd0, 17'd0));
    pending_items.push_back(make_eval(17'(ONE), 17'(ONE)));
    pending_items.push_back(make_eval(17'(ONE), 17'd0));
    pending_items.push_back(make_eval(17'h1ffff, 17'h1ffff));
    pending_items.push_back(make_eval(17'(ONE + 1), 17'd1));
    pending_items.push_back(make_eval(17'(ONE / 2), 17'(ONE / 2)));
    pending_items.push_back(make_eval(17'd1, 17'(ONE - 1)));
    for (int k = 0; k < GRID_POINTS; k++) begin
      pending_items.push_back(make_load(k / 4, k % 4, 32'sh7fffffff, 32'sh80000000,
                                        (k % 2) ? 32'sh7fffffff : 32'sh80000000));
    end
    pending_items.push_back(make_eval(17'(ONE / 3), 17'(2 * ONE / 3)));
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 8 : 0;
      recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 8 : 0;
      for (int n = 0; n < 350; n++) begin
        if ($urandom_range(9) < 3) begin
          pending_items.push_back(make_load($urandom_range(3), $urandom_range(3),
                                            rand_coord(), rand_coord(), rand_coord()));
        end else begin
          pending_items.push_back(make_eval(rand_param(), rand_param()));
        end
        // a stretch with no idling inside each phase
        if (n == 175) begin
          while (pending_items.size() > 0) @(posedge clk);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/bbp_pkg.sv
sv/bbp_if.sv
sv/bbp_front.sv
sv/bbp_lerp.sv
sv/bbp_eval.sv
sv/bicubic_bezier_patch_eval_unit.sv
sv/bbp_checker.sv
test/bbp_test_if.sv
test/bicubic_bezier_patch_eval_unit_test.sv
